>>> hdl/assert_macros.svh
// Assertion shorthands used by the checker of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while reset is held.
`define PFD_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pfd assertion failed");

// Next-cycle implication, off while reset is held.
`define PFD_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pfd assertion failed");

`endif

>>> hdl/pfd_pkg.sv
package pfd_pkg;

    localparam int DEF_VALUE_BITS   = 32;
    localparam int DEF_MAX_DISTINCT = 9;

    localparam int NUMBER_BITS = 32;
    localparam int PRIME_BITS  = 32;
    localparam int EXP_BITS    = 5;

    localparam logic [EXP_BITS-1:0] EXP_MAX = 5'd31;

endpackage

>>> hdl/pfd_ifs.sv
interface pfd_number_if;
    logic                             valid;
    logic                             ready;
    logic [pfd_pkg::NUMBER_BITS-1:0]  number_in;

    modport source (output valid, output number_in, input ready);
    modport sink   (input valid, input number_in, output ready);
endinterface

interface pfd_factor_if;
    logic                             valid;
    logic                             ready;
    logic [pfd_pkg::PRIME_BITS-1:0]   prime_factor;
    logic [pfd_pkg::EXP_BITS-1:0]     exponent;
    logic                             last_pair;

    modport source (output valid, output prime_factor, output exponent, output last_pair,
                    input ready);
    modport sink   (input valid, input prime_factor, input exponent, input last_pair,
                    output ready);
endinterface

>>> hdl/pfd_divider.sv
module pfd_divider #(
    parameter int VALUE_BITS = pfd_pkg::DEF_VALUE_BITS
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [VALUE_BITS-1:0] dividend,
    input  logic [VALUE_BITS-1:0] divisor,
    output logic                  done,
    output logic [VALUE_BITS-1:0] quotient,
    output logic [VALUE_BITS-1:0] remainder
);

    localparam int W  = VALUE_BITS;
    localparam int CW = $clog2(W + 1);

    logic          busy_reg;
    logic          done_reg;
    logic [CW-1:0] cnt_reg;
    logic [W-1:0]  quo_reg;
    logic [W:0]    part_reg;
    logic [W-1:0]  dvs_reg;

    logic [W:0]    shifted;
    logic [W:0]    diff;

    // One restoring step: bring down the next dividend bit and try the subtract.
    always_comb
    begin
        shifted = {part_reg[W-1:0], quo_reg[W-1]};
        diff    = shifted - {1'b0, dvs_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + CW'(1);
                if (cnt_reg == CW'(W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg  <= dividend;
            part_reg <= '0;
            dvs_reg  <= divisor;
        end
        else if (busy_reg)
        begin
            part_reg <= diff[W] ? shifted : diff;
            quo_reg  <= {quo_reg[W-2:0], ~diff[W]};
        end
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = part_reg[W-1:0];

endmodule

>>> hdl/prime_factorizer_trial_division.sv
// Prime factorizer by trial division.
// Input channel "number" carries one word, number_in; only its low VALUE_BITS
// bits are factored. Output channel "factor" returns one word per distinct
// prime, largest prime first: prime_factor, exponent, and last_pair set on the
// final word of the run. An input below 2 gives a single word (0, 0, last).
// Each trial is one pass of a shared restoring divider, one quotient bit a
// cycle. The divisor runs upward from 2 until it exceeds the square root of
// the remaining cofactor, with one extra division each time a factor is
// divided out. Result words then leave one per cycle while factor.ready is
// held high.
// number.ready is high only while the block is idle; it drops for the whole
// of the trial and the emission of results.
// The output is a register: a stalled receiver holds the current word, and
// the next input may be taken while the final word of a run still waits.
// Reset (rst_n low, asynchronous) empties the output register, returns the
// sequencer to idle and clears the prime count; no clearing pass is needed.
module prime_factorizer_trial_division #(
    parameter int VALUE_BITS   = pfd_pkg::DEF_VALUE_BITS,
    parameter int MAX_DISTINCT = pfd_pkg::DEF_MAX_DISTINCT
) (
    input  logic                clk,
    input  logic                rst_n,
    pfd_number_if.sink          number,
    pfd_factor_if.source        factor
);

    localparam int W     = VALUE_BITS;
    localparam int IDX_W = $clog2(MAX_DISTINCT);
    localparam int CNT_W = $clog2(MAX_DISTINCT + 1);
    localparam int EW    = pfd_pkg::EXP_BITS;
    localparam int PW    = pfd_pkg::PRIME_BITS;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_TAIL,
        S_EMIT
    } state_t;

    state_t           state_reg;
    logic [W-1:0]     rem_reg;
    logic [W-1:0]     d_reg;
    logic [EW-1:0]    exp_reg;
    logic [CNT_W-1:0] count_reg;
    logic [IDX_W-1:0] ptr_reg;
    logic             zero_reg;
    logic             start_reg;
    logic             out_valid_reg;
    logic [PW-1:0]    out_prime_reg;
    logic [EW-1:0]    out_exp_reg;
    logic             out_last_reg;

    logic [W-1:0]     prime_store [MAX_DISTINCT];
    logic [EW-1:0]    exp_store   [MAX_DISTINCT];

    logic             div_done;
    logic [W-1:0]     div_q;
    logic [W-1:0]     div_r;

    logic [W-1:0]     in_value;
    logic             full;
    logic             slot_free;
    logic [EW-1:0]    exp_inc;
    logic             wr_en;
    logic [W-1:0]     wr_prime;
    logic [EW-1:0]    wr_exp;
    logic             start_next;

    pfd_divider #(
        .VALUE_BITS (VALUE_BITS)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start_reg),
        .dividend  (rem_reg),
        .divisor   (d_reg),
        .done      (div_done),
        .quotient  (div_q),
        .remainder (div_r)
    );

    always_comb
    begin
        in_value  = W'(number.number_in);
        full      = (count_reg == CNT_W'(MAX_DISTINCT));
        slot_free = !out_valid_reg || factor.ready;
        exp_inc   = (exp_reg == pfd_pkg::EXP_MAX) ? exp_reg : exp_reg + EW'(1);

        wr_en    = 1'b0;
        wr_prime = d_reg;
        wr_exp   = exp_reg;
        // A divisor stops dividing: store it with its multiplicity.
        if (state_reg == S_DIV && div_done && exp_reg != '0 && div_r != '0 && !full)
        begin
            wr_en = 1'b1;
        end
        // Cofactor left above 1 is itself prime.
        if (state_reg == S_TAIL && rem_reg > W'(1) && !full)
        begin
            wr_en    = 1'b1;
            wr_prime = rem_reg;
            wr_exp   = EW'(1);
        end

        // Launch the next division unless the trial ends here.
        start_next = 1'b0;
        if (state_reg == S_IDLE && number.valid && in_value >= W'(2))
        begin
            start_next = 1'b1;
        end
        if (state_reg == S_DIV && div_done)
        begin
            if (exp_reg == '0)
            begin
                start_next = !(div_q < d_reg);
            end
            else
            begin
                start_next = (div_r == '0) || !full;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            prime_store[count_reg[IDX_W-1:0]] <= wr_prime;
            exp_store[count_reg[IDX_W-1:0]]   <= wr_exp;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rem_reg       <= '0;
            d_reg         <= W'(2);
            exp_reg       <= '0;
            count_reg     <= '0;
            ptr_reg       <= '0;
            zero_reg      <= 1'b0;
            start_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            out_prime_reg <= '0;
            out_exp_reg   <= '0;
            out_last_reg  <= 1'b0;
        end
        else
        begin
            start_reg <= start_next;
            if (out_valid_reg && factor.ready && state_reg != S_EMIT)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (number.valid)
                    begin
                        rem_reg   <= in_value;
                        d_reg     <= W'(2);
                        exp_reg   <= '0;
                        count_reg <= '0;
                        if (in_value < W'(2))
                        begin
                            zero_reg  <= 1'b1;
                            state_reg <= S_EMIT;
                        end
                        else
                        begin
                            zero_reg  <= 1'b0;
                            state_reg <= S_DIV;
                        end
                    end
                end

                S_DIV:
                begin
                    if (div_done)
                    begin
                        if (exp_reg == '0)
                        begin
                            // Divisor beyond the square root: trial over.
                            if (div_q < d_reg)
                            begin
                                state_reg <= S_TAIL;
                            end
                            else if (div_r == '0)
                            begin
                                rem_reg   <= div_q;
                                exp_reg   <= EW'(1);
                            end
                            else
                            begin
                                d_reg     <= d_reg + W'(1);
                            end
                        end
                        else if (div_r == '0)
                        begin
                            rem_reg   <= div_q;
                            exp_reg   <= exp_inc;
                        end
                        else if (full)
                        begin
                            // Table full: drop the rest and emit what is held.
                            ptr_reg   <= IDX_W'(count_reg - CNT_W'(1));
                            state_reg <= S_EMIT;
                        end
                        else
                        begin
                            count_reg <= count_reg + CNT_W'(1);
                            exp_reg   <= '0;
                            d_reg     <= d_reg + W'(1);
                        end
                    end
                end

                S_TAIL:
                begin
                    if (wr_en)
                    begin
                        count_reg <= count_reg + CNT_W'(1);
                        ptr_reg   <= count_reg[IDX_W-1:0];
                    end
                    else
                    begin
                        ptr_reg <= IDX_W'(count_reg - CNT_W'(1));
                    end
                    state_reg <= S_EMIT;
                end

                S_EMIT:
                begin
                    if (slot_free)
                    begin
                        out_valid_reg <= 1'b1;
                        if (zero_reg)
                        begin
                            out_prime_reg <= '0;
                            out_exp_reg   <= '0;
                            out_last_reg  <= 1'b1;
                            state_reg     <= S_IDLE;
                        end
                        else
                        begin
                            out_prime_reg <= PW'(prime_store[ptr_reg]);
                            out_exp_reg   <= exp_store[ptr_reg];
                            out_last_reg  <= (ptr_reg == '0);
                            if (ptr_reg == '0)
                            begin
                                state_reg <= S_IDLE;
                            end
                            else
                            begin
                                ptr_reg <= ptr_reg - IDX_W'(1);
                            end
                        end
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign number.ready        = (state_reg == S_IDLE);
    assign factor.valid        = out_valid_reg;
    assign factor.prime_factor = out_prime_reg;
    assign factor.exponent     = out_exp_reg;
    assign factor.last_pair    = out_last_reg;

endmodule

>>> hdl/pfd_checker.sv
`include "assert_macros.svh"

module pfd_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             in_valid,
    input logic                             in_ready,
    input logic                             out_valid,
    input logic                             out_ready,
    input logic [pfd_pkg::PRIME_BITS-1:0]   out_prime,
    input logic [pfd_pkg::EXP_BITS-1:0]     out_exp,
    input logic                             out_last
);

    // Hold a stalled word.
    `PFD_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_prime) && $stable(out_exp) && $stable(out_last))

    // A taken number closes the input.
    `PFD_ASSERT_NXT(a_busy_after_take, clk, rst_n, in_valid && in_ready, !in_ready)

    // Words of one run follow each other without a gap.
    `PFD_ASSERT_NXT(a_run_unbroken, clk, rst_n, out_valid && out_ready && !out_last, out_valid)

    // No new number while a run is still being delivered.
    `PFD_ASSERT_IMP(a_no_take_mid_run, clk, rst_n, out_valid && !out_last, !in_ready)

    // Exponent zero only on the lone word for an input below two.
    `PFD_ASSERT_IMP(a_zero_exp_word, clk, rst_n, out_valid && out_exp == '0, out_last && out_prime == '0)

endmodule

bind prime_factorizer_trial_division pfd_checker u_pfd_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (number.valid),
    .in_ready  (number.ready),
    .out_valid (factor.valid),
    .out_ready (factor.ready),
    .out_prime (factor.prime_factor),
    .out_exp   (factor.exponent),
    .out_last  (factor.last_pair)
);
